@@ src/adb_host_bus_transceiver_core_assert.svh @@
// Assertion macros shared by the desktop bus host checker.
`ifndef ADB_HOST_BUS_TRANSCEIVER_CORE_ASSERT_SVH
`define ADB_HOST_BUS_TRANSCEIVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ADB_HBT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("adb_hbt: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ADB_HBT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("adb_hbt: next-cycle check failed");

`endif

@@ src/adb_hbt_pkg.sv @@
// Shared types, codes and timing constants of the desktop bus host.
`timescale 1ns / 1ps

package adb_hbt_pkg;

  // Default payload capacity in bytes
  localparam int MAX_BYTES_DEF = 8;

  // Fixed bus timing in microseconds
  localparam logic [10:0] CELL_SHORT       = 11'd35;
  localparam logic [10:0] CELL_LONG        = 11'd65;
  localparam logic [10:0] STOP_LOW         = 11'd70;
  localparam logic [10:0] START_LOW_LIMIT  = 11'd40;
  localparam logic [10:0] START_HIGH_LIMIT = 11'd100;

  // Configuration reset values
  localparam logic [10:0] ATTN_RST    = 11'd800;
  localparam logic [9:0]  GAP_RST     = 10'd200;
  localparam logic [9:0]  TIMEOUT_RST = 10'd500;
  localparam logic [7:0]  CELLMAX_RST = 8'd130;

  // Configuration register indexes
  localparam logic [1:0] REG_ATTN    = 2'd0;
  localparam logic [1:0] REG_GAP     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_CELLMAX = 2'd3;

  // Bus command codes
  localparam logic [1:0] CMD_RESET  = 2'd0;
  localparam logic [1:0] CMD_FLUSH  = 2'd1;
  localparam logic [1:0] CMD_LISTEN = 2'd2;
  localparam logic [1:0] CMD_TALK   = 2'd3;

  // Request kinds carried on tuser
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_RELEASE = 3'd1,
    ST_START_HIGH = 3'd2,
    ST_START_LOW  = 3'd3,
    ST_SHORT      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ATTN   = 4'd1,
    PH_CL     = 4'd2,
    PH_CH     = 4'd3,
    PH_CSTOP  = 4'd4,
    PH_GAP    = 4'd5,
    PH_DL     = 4'd6,
    PH_DH     = 4'd7,
    PH_DSTOP  = 4'd8,
    PH_WREL   = 4'd9,
    PH_WSTART = 4'd10,
    PH_SLOW   = 4'd11,
    PH_SHIGH  = 4'd12,
    PH_RXL    = 4'd13,
    PH_RXH    = 4'd14
  } phase_t;

  typedef struct packed {
    logic [10:0] attention_low_us;
    logic [9:0]  stop_to_start_us;
    logic [9:0]  response_timeout_us;
    logic [7:0]  bit_cell_max_us;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic        line_in;
    logic [3:0]  dev_addr;
    logic [1:0]  command;
    logic [1:0]  reg_sel;
    logic [3:0]  data_len;
    logic [63:0] tx_data;
  } in_item_t;

  typedef struct packed {
    logic        line_drive_low;
    logic        busy_res;
    logic        done_res;
    status_t     status;
    logic [63:0] rx_data;
    logic [3:0]  rx_bytes;
  } result_t;

endpackage

@@ src/adb_hbt_engine.sv @@
// Transaction state and one-tick step logic of the desktop bus host.
`timescale 1ns / 1ps

module adb_hbt_engine #(
  parameter int MAX_BYTES = adb_hbt_pkg::MAX_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  adb_hbt_pkg::in_item_t item,
  input  adb_hbt_pkg::cfg_t     cfg,
  output adb_hbt_pkg::result_t  res
);

  localparam int SHIFT_W = MAX_BYTES * 8;
  localparam int BC_W    = $clog2(SHIFT_W + 2);
  localparam int IDX_W   = $clog2(SHIFT_W);

  adb_hbt_pkg::phase_t phase_r, phase_nxt;
  logic [10:0]         timer_r, timer_nxt;
  logic [BC_W-1:0]     bc_r, bc_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [7:0]          cmd_r, cmd_nxt;
  logic [7:0]          cell_r, cell_nxt;
  logic [3:0]          len_r, len_nxt;

  logic [10:0]         timer_inc;
  logic [10:0]         dur;
  logic                hit;
  logic                cbit;
  logic                dbit;
  logic [BC_W-1:0]     len8;
  logic [BC_W-1:0]     bc_inc;
  logic [1:0]          kind;
  logic                fin;
  adb_hbt_pkg::status_t code;
  logic                rx_bit;
  logic [7:0]          cell_inc;
  logic [11:0]         high_sum;

  assign timer_inc = timer_r + 11'd1;
  assign kind      = cmd_r[3:2];
  assign len8      = BC_W'({len_r, 3'b000});
  assign bc_inc    = bc_r + BC_W'(1);
  assign cell_inc  = (cell_r < 8'd255) ? cell_r + 8'd1 : cell_r;
  assign high_sum  = 12'(cell_r) + 12'(timer_inc);
  assign rx_bit    = (11'(cell_r) < timer_r);

  // Command bit: start bit is one, then command byte MSB first
  always_comb begin
    if (bc_r == '0) begin
      cbit = 1'b1;
    end else if (bc_r > BC_W'(8)) begin
      cbit = 1'b0;
    end else begin
      cbit = cmd_r[3'(4'd8 - 4'(bc_r))];
    end
  end

  // Payload bit: start bit is one, then the used bytes MSB first
  always_comb begin
    if (bc_r == '0) begin
      dbit = 1'b1;
    end else if (bc_r > len8) begin
      dbit = 1'b0;
    end else begin
      dbit = shift_r[IDX_W'(len8 - bc_r)];
    end
  end

  // Select the length of the current phase
  always_comb begin
    unique case (phase_r)
      adb_hbt_pkg::PH_ATTN:   dur = cfg.attention_low_us;
      adb_hbt_pkg::PH_CL:     dur = cbit ? adb_hbt_pkg::CELL_SHORT : adb_hbt_pkg::CELL_LONG;
      adb_hbt_pkg::PH_CH:     dur = cbit ? adb_hbt_pkg::CELL_LONG : adb_hbt_pkg::CELL_SHORT;
      adb_hbt_pkg::PH_CSTOP:  dur = adb_hbt_pkg::STOP_LOW;
      adb_hbt_pkg::PH_GAP:    dur = 11'(cfg.stop_to_start_us);
      adb_hbt_pkg::PH_DL:     dur = dbit ? adb_hbt_pkg::CELL_SHORT : adb_hbt_pkg::CELL_LONG;
      adb_hbt_pkg::PH_DH:     dur = dbit ? adb_hbt_pkg::CELL_LONG : adb_hbt_pkg::CELL_SHORT;
      adb_hbt_pkg::PH_DSTOP:  dur = adb_hbt_pkg::STOP_LOW;
      adb_hbt_pkg::PH_WREL:   dur = 11'(cfg.response_timeout_us);
      adb_hbt_pkg::PH_WSTART: dur = 11'(cfg.response_timeout_us);
      adb_hbt_pkg::PH_SLOW:   dur = adb_hbt_pkg::START_LOW_LIMIT;
      adb_hbt_pkg::PH_SHIGH:  dur = adb_hbt_pkg::START_HIGH_LIMIT;
      default:                dur = 11'd0;
    endcase
  end

  assign hit = (timer_inc >= dur);

  // Next state for one beat
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    bc_nxt    = bc_r;
    shift_nxt = shift_r;
    cmd_nxt   = cmd_r;
    cell_nxt  = cell_r;
    len_nxt   = len_r;
    fin       = 1'b0;
    code      = adb_hbt_pkg::ST_OK;

    if (item.req_type == adb_hbt_pkg::REQ_START) begin
      // Latch a new transaction only when idle
      if (phase_r == adb_hbt_pkg::PH_IDLE) begin
        len_nxt = (item.data_len > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : item.data_len;
        case (item.command)
          adb_hbt_pkg::CMD_RESET: cmd_nxt = {item.dev_addr, 4'b0000};
          adb_hbt_pkg::CMD_FLUSH: cmd_nxt = {item.dev_addr, 4'b0001};
          default:                cmd_nxt = {item.dev_addr, item.command, item.reg_sel};
        endcase
        shift_nxt = (item.command == adb_hbt_pkg::CMD_LISTEN) ?
                    item.tx_data[SHIFT_W-1:0] : '0;
        bc_nxt    = '0;
        timer_nxt = '0;
        cell_nxt  = '0;
        phase_nxt = adb_hbt_pkg::PH_ATTN;
      end
    end else begin
      unique case (phase_r)
        adb_hbt_pkg::PH_IDLE: begin
          phase_nxt = adb_hbt_pkg::PH_IDLE;
        end
        adb_hbt_pkg::PH_ATTN: begin
          timer_nxt = timer_inc;
          if (hit) begin
            timer_nxt = '0;
            bc_nxt    = '0;
            phase_nxt = adb_hbt_pkg::PH_CH;
          end
        end
        adb_hbt_pkg::PH_CL, adb_hbt_pkg::PH_DL: begin
          timer_nxt = timer_inc;
          if (hit) begin
            timer_nxt = '0;
            phase_nxt = (phase_r == adb_hbt_pkg::PH_CL) ? adb_hbt_pkg::PH_CH :
                                                          adb_hbt_pkg::PH_DH;
          end
        end
        adb_hbt_pkg::PH_CH: begin
          timer_nxt = timer_inc;
          if (hit) begin
            timer_nxt = '0;
            bc_nxt    = bc_inc;
            phase_nxt = (bc_inc >= BC_W'(9)) ? adb_hbt_pkg::PH_CSTOP : adb_hbt_pkg::PH_CL;
          end
        end
        adb_hbt_pkg::PH_CSTOP: begin
          timer_nxt = timer_inc;
          if (hit) begin
            timer_nxt = '0;
            if (kind == adb_hbt_pkg::CMD_TALK) begin
              bc_nxt    = '0;
              phase_nxt = adb_hbt_pkg::PH_WREL;
            end else begin
              phase_nxt = adb_hbt_pkg::PH_GAP;
            end
          end
        end
        adb_hbt_pkg::PH_GAP: begin
          timer_nxt = timer_inc;
          if (hit) begin
            timer_nxt = '0;
            if (kind == adb_hbt_pkg::CMD_LISTEN) begin
              bc_nxt    = '0;
              phase_nxt = adb_hbt_pkg::PH_DL;
            end else begin
              fin = 1'b1;
            end
          end
        end
        adb_hbt_pkg::PH_DH: begin
          timer_nxt = timer_inc;
          if (hit) begin
            timer_nxt = '0;
            bc_nxt    = bc_inc;
            phase_nxt = (bc_inc > len8) ? adb_hbt_pkg::PH_DSTOP : adb_hbt_pkg::PH_DL;
          end
        end
        adb_hbt_pkg::PH_DSTOP: begin
          timer_nxt = timer_inc;
          fin       = hit;
        end
        adb_hbt_pkg::PH_WREL: begin
          if (item.line_in) begin
            timer_nxt = '0;
            phase_nxt = adb_hbt_pkg::PH_WSTART;
          end else begin
            timer_nxt = timer_inc;
            fin       = hit;
            code      = adb_hbt_pkg::ST_NO_RELEASE;
          end
        end
        adb_hbt_pkg::PH_WSTART: begin
          if (!item.line_in) begin
            timer_nxt = '0;
            phase_nxt = adb_hbt_pkg::PH_SLOW;
          end else begin
            timer_nxt = timer_inc;
            fin       = hit;
            code      = (len_r == '0) ? adb_hbt_pkg::ST_OK : adb_hbt_pkg::ST_SHORT;
          end
        end
        adb_hbt_pkg::PH_SLOW: begin
          if (item.line_in) begin
            timer_nxt = '0;
            phase_nxt = adb_hbt_pkg::PH_SHIGH;
          end else begin
            timer_nxt = timer_inc;
            fin       = hit;
            code      = adb_hbt_pkg::ST_START_HIGH;
          end
        end
        adb_hbt_pkg::PH_SHIGH: begin
          if (!item.line_in) begin
            if (len_r == '0) begin
              fin = 1'b1;
            end else begin
              cell_nxt  = 8'd1;
              timer_nxt = '0;
              phase_nxt = adb_hbt_pkg::PH_RXL;
              fin       = (8'd1 >= cfg.bit_cell_max_us);
              code      = adb_hbt_pkg::ST_SHORT;
            end
          end else begin
            timer_nxt = timer_inc;
            fin       = hit;
            code      = adb_hbt_pkg::ST_START_LOW;
          end
        end
        adb_hbt_pkg::PH_RXL: begin
          code = adb_hbt_pkg::ST_SHORT;
          if (!item.line_in) begin
            cell_nxt = cell_inc;
            fin      = (cell_inc >= cfg.bit_cell_max_us);
          end else begin
            timer_nxt = 11'd1;
            phase_nxt = adb_hbt_pkg::PH_RXH;
            fin       = ({1'b0, cell_r} + 9'd1 >= {1'b0, cfg.bit_cell_max_us});
          end
        end
        adb_hbt_pkg::PH_RXH: begin
          if (item.line_in) begin
            timer_nxt = timer_inc;
            fin       = (high_sum >= 12'(cfg.bit_cell_max_us));
            code      = adb_hbt_pkg::ST_SHORT;
          end else begin
            // Close the cell: one when low was shorter than high
            shift_nxt = {shift_r[SHIFT_W-2:0], rx_bit};
            bc_nxt    = bc_inc;
            if (bc_inc >= len8) begin
              fin = 1'b1;
            end else begin
              cell_nxt  = 8'd1;
              timer_nxt = '0;
              phase_nxt = adb_hbt_pkg::PH_RXL;
              fin       = (8'd1 >= cfg.bit_cell_max_us);
              code      = adb_hbt_pkg::ST_SHORT;
            end
          end
        end
        default: begin
          phase_nxt = adb_hbt_pkg::PH_IDLE;
        end
      endcase

      if (fin) begin
        phase_nxt = adb_hbt_pkg::PH_IDLE;
      end
    end
  end

  // Build the result beat
  always_comb begin
    res = '0;
    res.busy_res = (phase_nxt != adb_hbt_pkg::PH_IDLE);
    if (item.req_type == adb_hbt_pkg::REQ_TICK) begin
      res.line_drive_low = (phase_r == adb_hbt_pkg::PH_ATTN)  ||
                           (phase_r == adb_hbt_pkg::PH_CL)    ||
                           (phase_r == adb_hbt_pkg::PH_DL)    ||
                           (phase_r == adb_hbt_pkg::PH_CSTOP) ||
                           (phase_r == adb_hbt_pkg::PH_DSTOP);
      if (fin) begin
        res.done_res = 1'b1;
        res.status   = code;
        if (kind == adb_hbt_pkg::CMD_TALK) begin
          res.rx_data  = 64'(shift_nxt);
          res.rx_bytes = 4'(bc_nxt >> 3);
        end
      end
    end
  end

  // Hold state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= adb_hbt_pkg::PH_IDLE;
      timer_r <= '0;
      bc_r    <= '0;
      cmd_r   <= '0;
      cell_r  <= '0;
      len_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      bc_r    <= bc_nxt;
      cmd_r   <= cmd_nxt;
      cell_r  <= cell_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      shift_r <= shift_nxt;
    end
  end

endmodule

@@ src/adb_host_bus_transceiver_core.sv @@
// Top level of the desktop bus host: stream ports, configuration and result register.
`timescale 1ns / 1ps

// Host for a single-wire open-drain desktop bus. Each input beat is either a
// one-microsecond tick (tuser low) carrying the sampled line level, or a start
// request (tuser high) carrying address, command, register and payload; a start
// request while a transaction runs is ignored. Every input beat yields exactly
// one result beat with the line drive for that tick, busy, a done pulse, status
// and the received talk data. The step logic feeds the output register, so the block
// takes one beat per clock as long as the result side takes its beats; in_tready
// drops only while a result waits and out_tready is low. Timing registers must be
// written on the cfg port while idle by the user; the block does not enforce it.
module adb_host_bus_transceiver_core #(
  parameter int MAX_BYTES = adb_hbt_pkg::MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] line_in, [4:1] dev_addr, [6:5] command, [8:7] reg_sel,
  // [12:9] data_len, [76:13] tx_data, [79:77] zero
  input  logic [79:0] in_tdata,
  // [0] req_type
  input  logic [0:0]  in_tuser,
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] line_drive_low, [1] busy_res, [2] done_res, [5:3] status,
  // [69:6] rx_data, [73:70] rx_bytes, [79:74] zero
  output logic [79:0] out_tdata,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  adb_hbt_pkg::cfg_t     cfg_r;
  adb_hbt_pkg::in_item_t item;
  adb_hbt_pkg::result_t  res;
  adb_hbt_pkg::result_t  out_data_r;
  logic                  out_valid_r;
  logic                  step_en;

  // Unpack the input beat
  assign item.req_type = in_tuser[0];
  assign item.line_in  = in_tdata[0];
  assign item.dev_addr = in_tdata[4:1];
  assign item.command  = in_tdata[6:5];
  assign item.reg_sel  = in_tdata[8:7];
  assign item.data_len = in_tdata[12:9];
  assign item.tx_data  = in_tdata[76:13];

  assign in_tready = !out_valid_r || out_tready;
  assign step_en   = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attention_low_us    <= adb_hbt_pkg::ATTN_RST;
      cfg_r.stop_to_start_us    <= adb_hbt_pkg::GAP_RST;
      cfg_r.response_timeout_us <= adb_hbt_pkg::TIMEOUT_RST;
      cfg_r.bit_cell_max_us     <= adb_hbt_pkg::CELLMAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        adb_hbt_pkg::REG_ATTN:    cfg_r.attention_low_us    <= cfg_wdata;
        adb_hbt_pkg::REG_GAP:     cfg_r.stop_to_start_us    <= cfg_wdata[9:0];
        adb_hbt_pkg::REG_TIMEOUT: cfg_r.response_timeout_us <= cfg_wdata[9:0];
        adb_hbt_pkg::REG_CELLMAX: cfg_r.bit_cell_max_us     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  adb_hbt_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= res;
    end
  end

  // Pack the result beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0,
                       out_data_r.rx_bytes,
                       out_data_r.rx_data,
                       out_data_r.status,
                       out_data_r.done_res,
                       out_data_r.busy_res,
                       out_data_r.line_drive_low};

endmodule

@@ src/adb_hbt_checker.sv @@
// Port-level checks on the desktop bus host, bound to its top level.
`timescale 1ns / 1ps
`include "adb_host_bus_transceiver_core_assert.svh"

module adb_hbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  logic       busy_b;
  logic       done_b;
  logic [2:0] status_b;
  logic [3:0] rx_bytes_b;
  logic       out_stall;
  logic       done_legal;
  logic       fields_clear;

  assign busy_b     = out_tdata[1];
  assign done_b     = out_tdata[2];
  assign status_b   = out_tdata[5:3];
  assign rx_bytes_b = out_tdata[73:70];

  assign out_stall    = out_tvalid && !out_tready;
  assign done_legal   = !busy_b && (status_b <= 3'(adb_hbt_pkg::ST_SHORT)) &&
                        (rx_bytes_b <= 4'd8);
  assign fields_clear = (status_b == 3'(adb_hbt_pkg::ST_OK)) && (rx_bytes_b == 4'd0);

  // A stalled result beat holds
  `ADB_HBT_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // An empty output register never blocks the input
  `ADB_HBT_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

  // A finishing beat leaves the block idle with a legal status and count
  `ADB_HBT_ASSERT_IMP(a_done_idle, clk, rst_n, out_tvalid && done_b, done_legal)

  // Status and byte count stay clear outside the done pulse
  `ADB_HBT_ASSERT_IMP(a_quiet_fields, clk, rst_n, out_tvalid && !done_b, fields_clear)

endmodule

bind adb_host_bus_transceiver_core adb_hbt_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/adb_host_bus_transceiver_core_tb.sv @@
// Self-checking testbench for the desktop bus host core with a bus device model.
`timescale 1ns / 1ps

import adb_hbt_pkg::*;

// Bus host predictor and the queue of result beats it has worked out.
class bus_host_scoreboard;
  cfg_t        timing;
  phase_t      phase;
  logic [10:0] timer;
  logic [6:0]  bit_cnt;
  logic [63:0] shreg;
  logic [7:0]  cmd_byte;
  logic [7:0]  low_time;
  logic [3:0]  len_held;
  result_t     expected_beats[$];
  int          mismatches;

  function new();
    timing     = '{ATTN_RST, GAP_RST, TIMEOUT_RST, CELLMAX_RST};
    phase      = PH_IDLE;
    timer      = '0;
    bit_cnt    = '0;
    shreg      = '0;
    cmd_byte   = '0;
    low_time   = '0;
    len_held   = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [10:0] val);
    case (idx)
      REG_ATTN:    timing.attention_low_us    = val;
      REG_GAP:     timing.stop_to_start_us    = val[9:0];
      REG_TIMEOUT: timing.response_timeout_us = val[9:0];
      REG_CELLMAX: timing.bit_cell_max_us     = val[7:0];
      default: ;
    endcase
  endfunction

  function bit bus_idle();
    return phase == PH_IDLE;
  endfunction

  // The device owns the line from release wait through reception.
  function bit awaiting_device();
    return phase inside {PH_WREL, PH_WSTART, PH_SLOW, PH_SHIGH, PH_RXL, PH_RXH};
  endfunction

  function bit timed(int unsigned dur);
    timer = timer + 11'd1;
    return timer >= dur;
  endfunction

  function bit cmd_bit(int c);
    if (c == 0) return 1'b1;
    if (c > 8) return 1'b0;
    return cmd_byte[8 - c];
  endfunction

  function bit data_bit(int c);
    int n;
    n = int'(len_held) * 8;
    if (c == 0) return 1'b1;
    if (c > n) return 1'b0;
    return shreg[n - c];
  endfunction

  function void start_cell();
    low_time = 8'd1;
    timer    = '0;
    phase    = PH_RXL;
  endfunction

  // Advance the host by one beat and return the result beat it produces.
  function result_t bus_host_step(in_item_t it);
    result_t    r;
    bit         ends;
    status_t    st;
    logic [1:0] kind;
    bit         b;
    r    = '0;
    ends = 1'b0;
    st   = ST_OK;
    kind = cmd_byte[3:2];
    if (it.req_type == REQ_START) begin
      if (phase == PH_IDLE) begin
        len_held = (it.data_len > MAX_BYTES_DEF) ? 4'(MAX_BYTES_DEF) : it.data_len;
        case (it.command)
          CMD_RESET: cmd_byte = {it.dev_addr, 4'b0000};
          CMD_FLUSH: cmd_byte = {it.dev_addr, 4'b0001};
          default:   cmd_byte = {it.dev_addr, it.command, it.reg_sel};
        endcase
        shreg    = (it.command == CMD_LISTEN) ? it.tx_data : '0;
        bit_cnt  = '0;
        timer    = '0;
        low_time = '0;
        phase    = PH_ATTN;
      end
    end else begin
      r.line_drive_low = phase inside {PH_ATTN, PH_CL, PH_DL, PH_CSTOP, PH_DSTOP};
      case (phase)
        PH_ATTN: begin
          if (timed(timing.attention_low_us)) begin
            timer = '0; bit_cnt = '0; phase = PH_CH;
          end
        end
        PH_CL: begin
          if (timed(cmd_bit(bit_cnt) ? CELL_SHORT : CELL_LONG)) begin
            timer = '0; phase = PH_CH;
          end
        end
        PH_CH: begin
          if (timed(cmd_bit(bit_cnt) ? CELL_LONG : CELL_SHORT)) begin
            timer   = '0;
            bit_cnt = bit_cnt + 7'd1;
            phase   = (bit_cnt >= 9) ? PH_CSTOP : PH_CL;
          end
        end
        PH_CSTOP: begin
          if (timed(STOP_LOW)) begin
            timer = '0;
            if (kind == CMD_TALK) begin
              bit_cnt = '0; phase = PH_WREL;
            end else begin
              phase = PH_GAP;
            end
          end
        end
        PH_GAP: begin
          if (timed(timing.stop_to_start_us)) begin
            timer = '0;
            if (kind == CMD_LISTEN) begin
              bit_cnt = '0; phase = PH_DL;
            end else begin
              ends = 1'b1; st = ST_OK;
            end
          end
        end
        PH_DL: begin
          if (timed(data_bit(bit_cnt) ? CELL_SHORT : CELL_LONG)) begin
            timer = '0; phase = PH_DH;
          end
        end
        PH_DH: begin
          if (timed(data_bit(bit_cnt) ? CELL_LONG : CELL_SHORT)) begin
            timer   = '0;
            bit_cnt = bit_cnt + 7'd1;
            phase   = (int'(bit_cnt) > int'(len_held) * 8) ? PH_DSTOP : PH_DL;
          end
        end
        PH_DSTOP: begin
          if (timed(STOP_LOW)) begin
            ends = 1'b1; st = ST_OK;
          end
        end
        PH_WREL: begin
          if (it.line_in) begin
            timer = '0; phase = PH_WSTART;
          end else if (timed(timing.response_timeout_us)) begin
            ends = 1'b1; st = ST_NO_RELEASE;
          end
        end
        PH_WSTART: begin
          if (!it.line_in) begin
            timer = '0; phase = PH_SLOW;
          end else if (timed(timing.response_timeout_us)) begin
            ends = 1'b1;
            st   = (len_held == 0) ? ST_OK : ST_SHORT;
          end
        end
        PH_SLOW: begin
          if (it.line_in) begin
            timer = '0; phase = PH_SHIGH;
          end else if (timed(START_LOW_LIMIT)) begin
            ends = 1'b1; st = ST_START_HIGH;
          end
        end
        PH_SHIGH: begin
          if (!it.line_in) begin
            if (len_held == 0) begin
              ends = 1'b1; st = ST_OK;
            end else begin
              start_cell();
              if (low_time >= timing.bit_cell_max_us) begin
                ends = 1'b1; st = ST_SHORT;
              end
            end
          end else if (timed(START_HIGH_LIMIT)) begin
            ends = 1'b1; st = ST_START_LOW;
          end
        end
        PH_RXL: begin
          if (!it.line_in) begin
            if (low_time < 8'd255) low_time = low_time + 8'd1;
            if (low_time >= timing.bit_cell_max_us) begin
              ends = 1'b1; st = ST_SHORT;
            end
          end else begin
            timer = 11'd1;
            phase = PH_RXH;
            if (int'(low_time) + 1 >= int'(timing.bit_cell_max_us)) begin
              ends = 1'b1; st = ST_SHORT;
            end
          end
        end
        PH_RXH: begin
          if (it.line_in) begin
            timer = timer + 11'd1;
            if (int'(low_time) + int'(timer) >= int'(timing.bit_cell_max_us)) begin
              ends = 1'b1; st = ST_SHORT;
            end
          end else begin
            // Decode the cell: short low against long high is a one
            b       = int'(low_time) < int'(timer);
            shreg   = {shreg[62:0], b};
            bit_cnt = bit_cnt + 7'd1;
            if (int'(bit_cnt) >= int'(len_held) * 8) begin
              ends = 1'b1; st = ST_OK;
            end else begin
              start_cell();
              if (low_time >= timing.bit_cell_max_us) begin
                ends = 1'b1; st = ST_SHORT;
              end
            end
          end
        end
        default: phase = PH_IDLE;
      endcase
      if (ends) begin
        r.done_res = 1'b1;
        r.status   = st;
        if (kind == CMD_TALK) begin
          r.rx_data  = shreg;
          r.rx_bytes = bit_cnt[6:3];
        end
        phase = PH_IDLE;
      end
    end
    r.busy_res = (phase != PH_IDLE);
    return r;
  endfunction

  function void note_beat(in_item_t it);
    expected_beats.push_back(bus_host_step(it));
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_beat(result_t got);
    result_t want;
    if (expected_beats.size() == 0) begin
      $error("result beat arrived with no expectation waiting");
      mismatches++;
      return;
    end
    want = expected_beats.pop_front();
    compare_field("line_drive_low", want.line_drive_low, got.line_drive_low);
    compare_field("busy_res", want.busy_res, got.busy_res);
    compare_field("done_res", want.done_res, got.done_res);
    compare_field("status", want.status, got.status);
    compare_field("rx_data", want.rx_data, got.rx_data);
    compare_field("rx_bytes", want.rx_bytes, got.rx_bytes);
  endfunction
endclass

module adb_host_bus_transceiver_core_tb;
  import adb_hbt_pkg::*;

  // Device reply shapes
  localparam int REPLY_FULL       = 0;
  localparam int REPLY_SHORT      = 1;
  localparam int REPLY_NO_RELEASE = 2;
  localparam int REPLY_SILENT     = 3;
  localparam int REPLY_START_LOW  = 4;
  localparam int REPLY_START_HIGH = 5;
  localparam int REPLY_LONG_CELL  = 6;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_TOTAL     = 1600;
  localparam int NUM_PHASES      = 4;
  localparam int PHASE_ITEMS     = ITEMS_TOTAL / NUM_PHASES;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_wdata = '0;

  bus_host_scoreboard sb;
  logic device_line[$];
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   pressure_count = 0;
  int   pressure_seen = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   sent_items = 0;

  adb_host_bus_transceiver_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial forever #1 clk = ~clk;

  // Stall the result side at random; hold off for a long stretch on request
  always @(posedge clk) begin
    if (pressure_seen != pressure_count) begin
      pressure_seen = pressure_count;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.line_drive_low = out_tdata[0];
      got.busy_res       = out_tdata[1];
      got.done_res       = out_tdata[2];
      got.status         = status_t'(out_tdata[5:3]);
      got.rx_data        = out_tdata[69:6];
      got.rx_bytes       = out_tdata[73:70];
      sb.check_beat(got);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("adb_host_bus_transceiver_core_tb failed");
      $finish;
    end
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.req_type = REQ_TICK;
    it.line_in  = 1'($urandom_range(0, 1));
    it.dev_addr = 4'($urandom_range(0, 15));
    it.command  = 2'($urandom_range(0, 3));
    it.reg_sel  = 2'($urandom_range(0, 3));
    it.data_len = 4'($urandom_range(0, 15));
    it.tx_data  = {$urandom, $urandom};
    return it;
  endfunction

  // Pick the idling pattern from the number of beats sent so far
  task automatic update_flow();
    int ph;
    ph = sent_items / PHASE_ITEMS;
    case (ph)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 62; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 62; end
      default: begin send_idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // Offer one beat after an optional idle gap and note it once accepted
  task automatic send_beat(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.req_type;
    in_tdata  <= {3'b000, it.tx_data, it.data_len, it.reg_sel, it.command,
                  it.dev_addr, it.line_in};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(it);
    sent_items++;
    update_flow();
  endtask

  task automatic hold_line(input logic level, input int n);
    repeat (n) device_line.push_back(level);
  endtask

  // Script the device side of a talk, one line level per tick
  task automatic build_reply(input int shape, input int nbytes);
    int   tmo, nbits, bad_bit, lo, hi;
    logic bv;
    tmo = sb.timing.response_timeout_us;
    if (shape == REPLY_NO_RELEASE) begin
      hold_line(1'b0, tmo + 3);
      return;
    end
    hold_line(1'b0, $urandom_range(0, (tmo > 6) ? 6 : tmo - 1));
    hold_line(1'b1, 1 + $urandom_range(0, (tmo > 150) ? 150 : tmo - 1));
    if (shape == REPLY_SILENT) return;
    if (shape == REPLY_START_LOW) begin
      hold_line(1'b0, $urandom_range(45, 60));
      return;
    end
    hold_line(1'b0, $urandom_range(30, 40));
    // Released line after this point lets the start high time run out
    if (shape == REPLY_START_HIGH) return;
    hold_line(1'b1, $urandom_range(55, 75));
    nbits = nbytes * 8;
    if (shape == REPLY_SHORT && nbits > 0) nbits = $urandom_range(0, nbits - 1);
    bad_bit = -1;
    if (shape == REPLY_LONG_CELL && nbits > 0) bad_bit = $urandom_range(0, nbits - 1);
    for (int i = 0; i < nbits; i++) begin
      bv = 1'($urandom_range(0, 1));
      lo = (bv ? 35 : 65) + int'($urandom_range(0, 8)) - 4;
      hi = (bv ? 65 : 35) + int'($urandom_range(0, 8)) - 4;
      if (i == bad_bit) begin
        if ($urandom_range(0, 1)) lo += 150;
        else hi += 150;
      end
      hold_line(1'b0, lo);
      hold_line(1'b1, hi);
    end
    // Stop bit, then the line is released
    hold_line(1'b0, $urandom_range(65, 75));
  endtask

  // Run one bus transaction from start request until the host goes idle
  // or the beat budget runs out
  task automatic run_transfer(input logic [3:0] addr, input logic [1:0] cmd,
                              input logic [1:0] rsel, input logic [3:0] len,
                              input logic [63:0] payload, input int shape);
    in_item_t it;
    device_line.delete();
    if (cmd == CMD_TALK) build_reply(shape, (len > MAX_BYTES_DEF) ? MAX_BYTES_DEF : len);
    it          = random_item();
    it.req_type = REQ_START;
    it.dev_addr = addr;
    it.command  = cmd;
    it.reg_sel  = rsel;
    it.data_len = len;
    it.tx_data  = payload;
    send_beat(it);
    while (!sb.bus_idle() && sent_items < ITEMS_TOTAL) begin
      it = random_item();
      // Drop in a stray start request now and then; it must be ignored
      if ($urandom_range(0, 199) == 0) begin
        it.req_type = REQ_START;
      end else if (sb.awaiting_device()) begin
        it.line_in = (device_line.size() != 0) ? device_line.pop_front() : 1'b1;
      end
      send_beat(it);
    end
    // Ticks while idle
    repeat ($urandom_range(0, 3)) begin
      if (sent_items < ITEMS_TOTAL) send_beat(random_item());
    end
  endtask

  task automatic random_transfer();
    int         roll, len, shape;
    logic [1:0] cmd;
    roll = $urandom_range(0, 99);
    cmd  = (roll < 15) ? CMD_RESET : (roll < 30) ? CMD_FLUSH :
           (roll < 55) ? CMD_LISTEN : CMD_TALK;
    roll = $urandom_range(0, 99);
    len  = (roll < 70) ? $urandom_range(0, 2) : (roll < 85) ? $urandom_range(3, 7) :
           (roll < 95) ? MAX_BYTES_DEF : $urandom_range(9, 15);
    roll  = $urandom_range(0, 99);
    shape = (roll < 55) ? REPLY_FULL : (roll < 70) ? REPLY_SHORT :
            (roll < 76) ? REPLY_NO_RELEASE : (roll < 82) ? REPLY_SILENT :
            (roll < 88) ? REPLY_START_LOW : (roll < 94) ? REPLY_START_HIGH :
            REPLY_LONG_CELL;
    run_transfer(4'($urandom_range(0, 15)), cmd, 2'($urandom_range(0, 3)), 4'(len),
                 {$urandom, $urandom}, shape);
  endtask

  // Stop offering beats and wait for every expected result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timing(input cfg_t t);
    logic [1:0]  regs[4];
    logic [10:0] vals[4];
    regs = '{REG_ATTN, REG_GAP, REG_TIMEOUT, REG_CELLMAX};
    vals = '{t.attention_low_us, 11'(t.stop_to_start_us),
             11'(t.response_timeout_us), 11'(t.bit_cell_max_us)};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    cfg_t fast_timing;
    sb = new();
    fast_timing = '{11'd100, 10'd0, 10'd40, 8'd130};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle ticks at the reset timing, then a faster bus timing
    repeat (4) send_beat(random_item());
    drain();
    load_timing(fast_timing);

    // Long receiver hold-off while the sender keeps offering ticks
    pressure_count++;
    run_transfer(4'h9, CMD_TALK, 2'd2, 4'd0, '0, REPLY_FULL);

    // Random transactions until the beat budget is spent
    while (sent_items < ITEMS_TOTAL) random_transfer();

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("adb_host_bus_transceiver_core_tb passed");
    end else begin
      $display("adb_host_bus_transceiver_core_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/adb_hbt_pkg.sv
src/adb_hbt_engine.sv
src/adb_host_bus_transceiver_core.sv
src/adb_hbt_checker.sv
tb/adb_host_bus_transceiver_core_tb.sv
